// File: rtl/stbs_pkg.sv
// package with shared constants and types of the sorted table search block
`timescale 1ns / 1ps

package stbs_pkg;

  localparam int unsigned TABLE_DEPTH = 1024;
  localparam int unsigned VALUE_WIDTH = 32;
  localparam int unsigned IDX_W       = $clog2(TABLE_DEPTH);
  localparam int unsigned SIZE_W      = IDX_W + 1;
  localparam int unsigned FIELD_W     = 32;

  // configuration port
  localparam int unsigned APB_AW        = 3;
  localparam int unsigned APB_DW        = 32;
  localparam logic [APB_AW-1:0] ADDR_TABLE_SIZE = 3'd0;

  typedef enum logic {
    KIND_LOAD   = 1'b0,
    KIND_SEARCH = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PROBE,
    ST_CMP,
    ST_EMIT
  } state_e;

  typedef logic signed [VALUE_WIDTH-1:0] value_t;
  typedef logic [IDX_W-1:0]              idx_t;
  typedef logic [SIZE_W-1:0]             size_t;

endpackage

// File: rtl/stbs_if.sv
// item channels of the sorted table search block
`timescale 1ns / 1ps

interface stbs_req_if;
  logic                                valid;
  logic                                ready;
  logic                                kind;
  logic [stbs_pkg::IDX_W-1:0]          entry_index;
  logic signed [stbs_pkg::FIELD_W-1:0] entry_value;
  logic signed [stbs_pkg::FIELD_W-1:0] search_key;

  modport source (output valid, kind, entry_index, entry_value, search_key, input ready);
  modport sink   (input valid, kind, entry_index, entry_value, search_key, output ready);
endinterface

interface stbs_rsp_if;
  logic                       valid;
  logic                       ready;
  logic                       found;
  logic [stbs_pkg::IDX_W-1:0] position;

  modport source (output valid, found, position, input ready);
  modport sink   (input valid, found, position, output ready);
endinterface

// File: rtl/stbs_ram.sv
// single port write, single port read synchronous ram with registered read data
`timescale 1ns / 1ps

module stbs_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// File: rtl/sorted_table_binary_search_top.sv
// top level of the sorted table binary search block
`timescale 1ns / 1ps

// binary search over a table of signed entries held in one synchronous ram.
// a load item writes one entry without leaving the idle state; it gives no
// result. a search item walks the first table_size entries (saturated to the
// table depth) and gives one result: found with the probed position, or not
// found with position 0. each probe issues the ram read in ST_PROBE and
// compares the registered read data with the key in ST_CMP. a search ends in
// ST_EMIT, straight after the compare on a hit, or on a miss after one more
// ST_PROBE finds the range empty; ST_EMIT waits until the output register is
// free. a full table of 1024 entries needs at most 11 probes per search
// (ending in a miss).
// items are taken one at a time: a new item is accepted once the previous
// search has moved its result into the output register, so a result may wait
// there while the next item is already accepted. table_size is written over
// the apb port at byte address 0; the user must write it only while the
// block is idle, the block itself does not enforce this. entries must be
// loaded before a search probes them.
module sorted_table_binary_search_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [stbs_pkg::APB_AW-1:0]   paddr,
  input  logic [stbs_pkg::APB_DW-1:0]   pwdata,
  output logic [stbs_pkg::APB_DW-1:0]   prdata,
  output logic                          pready,
  // item channels
  stbs_req_if.sink                      req_i,
  stbs_rsp_if.source                    rsp_o
);

  import stbs_pkg::*;

  state_e state_q, state_d;

  size_t  size_q;          // table_size register as written
  size_t  size_eff;        // saturated to the table depth
  size_t  lo_q, lo_d;      // inclusive lower bound
  size_t  hi_q, hi_d;      // exclusive upper bound
  size_t  mid;
  idx_t   mid_q;
  value_t key_q;
  value_t rdata;
  logic   found_q, found_d;
  logic   rsp_valid_q;
  logic   rsp_found_q;
  idx_t   rsp_pos_q;

  logic   req_fire;
  logic   cfg_write;
  logic   load_we;
  logic   ram_re;
  logic   range_empty;
  logic   hit;
  logic   key_above;
  logic   out_free;

  // ---------------------------------------------------------------------------
  // configuration register
  // ---------------------------------------------------------------------------
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && (paddr == ADDR_TABLE_SIZE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= '0;
    end else if (cfg_write) begin
      size_q <= pwdata[SIZE_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == ADDR_TABLE_SIZE) begin
      prdata = {{(APB_DW-SIZE_W){1'b0}}, size_q};
    end
  end

  assign size_eff = (size_q > SIZE_W'(TABLE_DEPTH)) ? SIZE_W'(TABLE_DEPTH) : size_q;

  // ---------------------------------------------------------------------------
  // table memory
  // ---------------------------------------------------------------------------
  assign req_fire = req_i.valid && req_i.ready;
  assign load_we  = req_fire && (kind_e'(req_i.kind) == KIND_LOAD);

  // midpoint of the live range, biased low: lo + (hi - 1 - lo) / 2
  assign mid         = lo_q + ((hi_q - lo_q - SIZE_W'(1)) >> 1);
  assign range_empty = (lo_q >= hi_q);
  assign ram_re      = (state_q == ST_PROBE) && !range_empty;

  stbs_ram #(
    .DEPTH (TABLE_DEPTH),
    .WIDTH (VALUE_WIDTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (load_we),
    .waddr_i (req_i.entry_index),
    .wdata_i (VALUE_WIDTH'(req_i.entry_value)),
    .re_i    (ram_re),
    .raddr_i (mid[IDX_W-1:0]),
    .rdata_o (rdata)
  );

  assign hit       = (rdata == key_q);
  assign key_above = (rdata < key_q);   // signed compare
  assign out_free  = !rsp_valid_q || rsp_o.ready;

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (req_fire && (kind_e'(req_i.kind) == KIND_SEARCH)) begin
          state_d = ST_PROBE;
        end
      end
      ST_PROBE: begin
        state_d = range_empty ? ST_EMIT : ST_CMP;
      end
      ST_CMP: begin
        state_d = hit ? ST_EMIT : ST_PROBE;
      end
      ST_EMIT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    lo_d    = lo_q;
    hi_d    = hi_q;
    found_d = found_q;
    unique case (state_q)
      ST_IDLE: begin
        lo_d    = '0;
        hi_d    = size_eff;
        found_d = 1'b0;
      end
      ST_CMP: begin
        if (hit) begin
          found_d = 1'b1;
        end else if (key_above) begin
          lo_d = {1'b0, mid_q} + SIZE_W'(1);
        end else begin
          hi_d = {1'b0, mid_q};
        end
      end
      default: ;
    endcase
  end

  assign req_i.ready = (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      lo_q    <= '0;
      hi_q    <= '0;
      found_q <= 1'b0;
    end else begin
      state_q <= state_d;
      lo_q    <= lo_d;
      hi_q    <= hi_d;
      found_q <= found_d;
    end
  end

  // key and probe position need no reset
  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      key_q <= VALUE_WIDTH'(req_i.search_key);
    end
    if (ram_re) begin
      mid_q <= mid[IDX_W-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if ((state_q == ST_EMIT) && out_free) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == ST_EMIT) && out_free) begin
      rsp_found_q <= found_q;
      rsp_pos_q   <= found_q ? mid_q : '0;
    end
  end

  assign rsp_o.valid    = rsp_valid_q;
  assign rsp_o.found    = rsp_found_q;
  assign rsp_o.position = rsp_pos_q;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  // items enter only while no search is in flight
  a_accept_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_fire |-> (state_q == ST_IDLE))
    else $error("item accepted during a search");

  // the search range never inverts while probing
  a_range_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CMP) |-> (lo_q < hi_q) && (hi_q <= SIZE_W'(TABLE_DEPTH)))
    else $error("search bounds out of order");

  // a new result only ever comes from the end of a search
  a_rsp_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_valid_q) |-> ($past(state_q) == ST_EMIT))
    else $error("result raised outside a search");

  // a miss reports position zero
  a_miss_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_q && !rsp_found_q) |-> (rsp_pos_q == '0))
    else $error("miss with nonzero position");

endmodule

// File: verif/sorted_table_binary_search_top_tb.sv
// self-checking testbench of the sorted table binary search block
`timescale 1ns / 1ps

module sorted_table_binary_search_top_tb;
  import stbs_pkg::*;

  localparam int unsigned CLK_HALF        = 5;
  localparam int unsigned RESET_CYCLES    = 7;
  // covers the longest search, plus the output register and a stalled receiver
  localparam int unsigned SETTLE_CYCLES   = 48;
  localparam int unsigned WATCHDOG_LIMIT  = 4000;
  localparam int unsigned REPORT_LIMIT    = 10;
  localparam int unsigned PHASE_COUNT     = 15;
  // tables up to this size are loaded in full, larger ones only where probes reach
  localparam int unsigned FULL_FILL_LIMIT = 64;
  localparam int unsigned TREE_LEVELS     = 6;
  localparam int unsigned KEY_TRIES       = 8;

  localparam value_t VALUE_MIN = value_t'(32'h8000_0000);
  localparam value_t VALUE_MAX = value_t'(32'h7fff_ffff);

  // one search outcome
  typedef struct packed {
    logic found;
    idx_t position;
  } lookup_t;

  // shadow table, size register and the outcomes still owed by the block
  class search_scoreboard;
    value_t      table_mem [TABLE_DEPTH];
    size_t       table_size = '0;
    lookup_t     expected_lookups [$];
    int unsigned mismatches = 0;

    // probe midpoints over the first table_size entries, right bound exclusive
    function lookup_t find_key(value_t key);
      int unsigned n;
      int unsigned lo;
      int unsigned hi;
      int unsigned mid;
      lookup_t     r;
      n  = (table_size > TABLE_DEPTH) ? TABLE_DEPTH : int'(table_size);
      lo = 0;
      hi = n;
      r  = '0;
      while (lo < hi) begin
        mid = lo + (hi - 1 - lo) / 2;
        if (table_mem[mid] == key) begin
          r.found    = 1'b1;
          r.position = idx_t'(mid);
          return r;
        end
        if (table_mem[mid] < key) lo = mid + 1;
        else hi = mid;
      end
      return r;
    endfunction

    function void note_item(kind_e kind, idx_t index, value_t value, value_t key);
      if (kind == KIND_LOAD) table_mem[index] = value;
      else expected_lookups.push_back(find_key(key));
    endfunction

    function void check_result(logic found, idx_t position);
      lookup_t want;
      if (expected_lookups.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("unexpected result: found=%0d position=%0d", found, position);
        return;
      end
      want = expected_lookups.pop_front();
      if (found !== want.found || position !== want.position) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("result mismatch: found exp=%0d act=%0d, position exp=%0d act=%0d",
                   want.found, found, want.position, position);
      end
    endfunction
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  stbs_req_if req_bus ();
  stbs_rsp_if rsp_bus ();

  sorted_table_binary_search_top dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .req_i   (req_bus),
    .rsp_o   (rsp_bus)
  );

  search_scoreboard sb;

  // entries loaded so far, so that no search ever probes an unwritten entry
  bit          written_map [TABLE_DEPTH];
  // values as driven, ahead of the scoreboard's copy
  value_t      drive_mem [TABLE_DEPTH];
  // entries that a fill loads
  bit          probe_map [TABLE_DEPTH];
  // sender burst bookkeeping
  int unsigned burst_left = 0;
  // receiver stall pattern
  int unsigned stall_mode = 0;
  int unsigned mode_left  = 0;
  int unsigned stall_left = 0;
  int unsigned idle_cycles = 0;
  int unsigned phase_sizes [PHASE_COUNT] = '{1, 2, 3, 5, 1024, 2047, 0, 9, 16, 33, 2, 64,
                                              1, 100, 7};

  always #(CLK_HALF) clk_i = ~clk_i;

  // drive one item; between bursts the sender drops valid for a random gap
  task automatic send_item(kind_e kind, idx_t index, value_t value, value_t key);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
      // mostly short gaps, now and then a longer one that can outlast a whole search
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 30) : $urandom_range(0, 6);
      if (gap != 0) begin
        req_bus.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    req_bus.valid       <= 1'b1;
    req_bus.kind        <= kind;
    req_bus.entry_index <= index;
    req_bus.entry_value <= value;
    req_bus.search_key  <= key;
    if (kind == KIND_LOAD) begin
      written_map[index] = 1'b1;
      drive_mem[index]   = value;
    end
    @(posedge clk_i);
    while (!req_bus.ready) @(posedge clk_i);
    burst_left--;
  endtask

  // unused fields of an item carry random values
  task automatic load_entry(idx_t index, value_t value);
    send_item(KIND_LOAD, index, value, value_t'($urandom));
  endtask

  task automatic search_for(value_t key);
    send_item(KIND_SEARCH, idx_t'($urandom), value_t'($urandom), key);
  endtask

  // hold the sender until every search has answered and the block is quiet
  task automatic drain();
    req_bus.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (sb.expected_lookups.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // apb setup and access cycle, only ever issued while the block is idle
  task automatic write_table_size(size_t n);
    drain();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_TABLE_SIZE;
    pwdata  <= APB_DW'(n);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.table_size = n;
  endtask

  // top levels of the probe tree of the range [lo, hi)
  function automatic void mark_tree(int unsigned lo, int unsigned hi, int unsigned depth);
    int unsigned mid;
    if (lo >= hi || depth >= TREE_LEVELS) return;
    mid = lo + (hi - 1 - lo) / 2;
    probe_map[mid] = 1'b1;
    mark_tree(lo, mid, depth + 1);
    mark_tree(mid + 1, hi, depth + 1);
  endfunction

  // load ascending entries: spread over the full range, or packed with duplicates;
  // a large table gets only the upper probe tree and both outer probe paths
  task automatic fill_table(int unsigned n);
    longint      span;
    longint      v;
    longint      prev;
    bit          packed_mode;
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    if (n == 0) return;
    for (int unsigned i = 0; i < TABLE_DEPTH; i++) probe_map[i] = (n <= FULL_FILL_LIMIT);
    if (n > FULL_FILL_LIMIT) begin
      mark_tree(0, n, 0);
      lo = 0;
      hi = n;
      while (lo < hi) begin
        mid = lo + (hi - 1 - lo) / 2;
        probe_map[mid] = 1'b1;
        hi = mid;
      end
      lo = 0;
      hi = n;
      while (lo < hi) begin
        mid = lo + (hi - 1 - lo) / 2;
        probe_map[mid] = 1'b1;
        lo = mid + 1;
      end
    end
    packed_mode = 1'($urandom_range(0, 1));
    span = 64'sh1_0000_0000 / longint'(n);
    prev = ($urandom_range(0, 1) != 0) ? longint'($signed($urandom))
                                       : longint'($urandom_range(0, 6)) - 3;
    for (int unsigned i = 0; i < n; i++) begin
      if (!probe_map[i]) continue;
      if (packed_mode) begin
        v = (i == 0) ? prev : prev + longint'($urandom_range(0, 2));
        if (v > 64'sd2147483647) v = 64'sd2147483647;
        prev = v;
      end else begin
        v = -64'sd2147483648 + longint'(i) * span + longint'($urandom_range(0, 32'(span - 1)));
      end
      load_entry(idx_t'(i), value_t'(v));
    end
  endtask

  // true when every entry that a search for key would probe is loaded
  function automatic bit path_written(value_t key, int unsigned n);
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    lo = 0;
    hi = n;
    while (lo < hi) begin
      mid = lo + (hi - 1 - lo) / 2;
      if (!written_map[mid]) return 1'b0;
      if (drive_mem[mid] == key) return 1'b1;
      if (drive_mem[mid] < key) lo = mid + 1;
      else hi = mid;
    end
    return 1'b1;
  endfunction

  // a random loaded index below n, else the first probe position
  function automatic int unsigned written_index(int unsigned n);
    int unsigned i;
    i = $urandom_range(0, n - 1);
    return written_map[i] ? i : (n - 1) / 2;
  endfunction

  // one table size: mostly searches for present, neighboring and random keys,
  // the rest loads that either leave the searched range alone or disturb it
  task automatic run_phase(int unsigned size_value, int unsigned items);
    int unsigned n;
    int unsigned idx;
    int unsigned r;
    value_t      key;
    n = (size_value > TABLE_DEPTH) ? TABLE_DEPTH : size_value;
    write_table_size(size_t'(size_value));
    fill_table(n);
    for (int unsigned k = 0; k < items; k++) begin
      if (k == items / 2 && $urandom_range(0, 1) != 0) drain();
      if ($urandom_range(0, 9) < 7) begin
        key = '0;
        for (int unsigned t = 0; t < KEY_TRIES; t++) begin
          r = $urandom_range(0, 9);
          if (n != 0 && r < 5) begin
            key = drive_mem[written_index(n)];
          end else if (n != 0 && r < 7) begin
            key = drive_mem[written_index(n)]
                  + (($urandom_range(0, 1) != 0) ? 32'sd1 : -32'sd1);
          end else if (r == 7) begin
            key = ($urandom_range(0, 1) != 0) ? VALUE_MIN : VALUE_MAX;
          end else begin
            key = value_t'($urandom);
          end
          if (path_written(key, n)) break;
        end
        // the first probe position is always loaded
        if (!path_written(key, n)) key = drive_mem[(n - 1) / 2];
        search_for(key);
      end else begin
        r = $urandom_range(0, 9);
        if (r < 6 && n < TABLE_DEPTH) begin
          // outside the searched range
          load_entry(idx_t'($urandom_range(n, TABLE_DEPTH - 1)), value_t'($urandom));
        end else if (r < 9 && n != 0) begin
          // rewrite an entry with its own value, the order holds
          idx = written_index(n);
          load_entry(idx_t'(idx), drive_mem[idx]);
        end else begin
          // anywhere, may leave the table unsorted
          load_entry(idx_t'($urandom), value_t'($urandom));
        end
      end
    end
  endtask

  // accepted items and results, sampled at the edge that takes them
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (req_bus.valid && req_bus.ready)
        sb.note_item(kind_e'(req_bus.kind), req_bus.entry_index, req_bus.entry_value,
                     req_bus.search_key);
      if (rsp_bus.valid && rsp_bus.ready)
        sb.check_result(rsp_bus.found, rsp_bus.position);
    end
  end

  // receiver: always ready, sparse ready, coin flips, or long random stalls
  always @(posedge clk_i) begin
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      mode_left  = $urandom_range(20, 120);
    end
    mode_left--;
    case (stall_mode)
      0: begin
        rsp_bus.ready <= 1'b1;
      end
      1: begin
        rsp_bus.ready <= ($urandom_range(0, 2) == 0);
      end
      2: begin
        rsp_bus.ready <= 1'($urandom_range(0, 1));
      end
      default: begin
        if (stall_left != 0) begin
          rsp_bus.ready <= 1'b0;
          stall_left--;
        end else begin
          rsp_bus.ready <= 1'b1;
          if ($urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 20);
        end
      end
    endcase
  end

  // watchdog on cycles in which no handshake of any kind happens
  always @(posedge clk_i) begin
    if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
        (psel && penable)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    sb = new;
    rst_ni              <= 1'b0;
    psel                <= 1'b0;
    penable             <= 1'b0;
    pwrite              <= 1'b0;
    paddr               <= '0;
    pwdata              <= '0;
    req_bus.valid       <= 1'b0;
    req_bus.kind        <= KIND_LOAD;
    req_bus.entry_index <= '0;
    req_bus.entry_value <= '0;
    req_bus.search_key  <= '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty table straight after reset: nothing is probed
    search_for('0);
    search_for(VALUE_MAX);
    // last index, never probed below a full table
    load_entry(idx_t'(TABLE_DEPTH - 1), -32'sd1);
    // extremes and a pair of duplicates
    load_entry(idx_t'(0), VALUE_MIN);
    load_entry(idx_t'(1), 32'sd5);
    load_entry(idx_t'(2), 32'sd5);
    load_entry(idx_t'(3), VALUE_MAX);
    write_table_size(size_t'(4));
    search_for(VALUE_MIN);
    search_for(VALUE_MAX);
    search_for(32'sd5);
    search_for(32'sd4);
    search_for(-32'sd1);
    search_for('0);
    // unsorted table: the probe walks past a present key
    write_table_size(size_t'(3));
    load_entry(idx_t'(1), 32'sd100);
    search_for(32'sd5);
    search_for(32'sd100);
    search_for(VALUE_MIN);

    // random part over several sizes, full and oversized among them
    for (int unsigned p = 0; p < PHASE_COUNT; p++)
      run_phase(phase_sizes[p], $urandom_range(20, 30));

    drain();
    if (sb.mismatches == 0 && sb.expected_lookups.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/stbs_pkg.sv
rtl/stbs_if.sv
rtl/stbs_ram.sv
rtl/sorted_table_binary_search_top.sv
verif/sorted_table_binary_search_top_tb.sv
